FILE: src/rrm_pkg.sv
package rrm_pkg;

    localparam int X_SIZE_DEF     = 128;
    localparam int Y_SIZE_DEF     = 1024;
    localparam int VALUE_BITS_DEF = 10;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_QUERY    = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_INS_RD,
        ST_INS_WR,
        ST_QX_L,
        ST_QX_R,
        ST_QX_SH,
        ST_QY_L,
        ST_QY_LW,
        ST_QY_R,
        ST_QY_RW,
        ST_QY_SH
    } t_state;

endpackage

FILE: src/rrm_ram.sv
module rrm_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/rect_range_max_store_top.sv
// Two-dimensional range-maximum store over an X_SIZE by Y_SIZE grid, kept as a
// segment tree along x whose every node is a segment tree along y, all held in
// one single-port-read, single-port-write RAM with 2^(XI+YI) words. A command
// beat is taken when i_start is high and o_busy is low; o_busy then stays high
// until the command is finished, except for the unused code and for bounds off
// the grid, which end at once. Only a query returns a result: it appears on
// o_found and o_max_value, marked by o_valid for exactly one cycle, and the
// receiver cannot stall it. An insert walks every covering node, one RAM read
// and one write per node. A query visits each selected node with one read and
// one compare. A clear, and the clearing pass that follows reset, writes every
// RAM word once, and no command is taken until it is done. Stored words hold
// zero for empty, else value+1.
module rect_range_max_store_top
    import rrm_pkg::*;
#(
    parameter int X_SIZE     = X_SIZE_DEF,
    parameter int Y_SIZE     = Y_SIZE_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_operation,
    input  logic [6:0]  i_x_low,
    input  logic [6:0]  i_x_high,
    input  logic [9:0]  i_y_low,
    input  logic [9:0]  i_y_high,
    input  logic [9:0]  i_value,
    output logic        o_valid,
    output logic        o_found,
    output logic [9:0]  o_max_value
);

    // Node index widths and loop counter widths (counters may reach 2*SIZE).
    localparam int XI = $clog2(2 * X_SIZE);
    localparam int YI = $clog2(2 * Y_SIZE);
    localparam int XC = $clog2(2 * X_SIZE + 1);
    localparam int YC = $clog2(2 * Y_SIZE + 1);
    localparam int AW = XI + YI;
    localparam int CW = VALUE_BITS + 1;

    t_state          r_state, n_state;
    logic [XI-1:0]   r_i, n_i;
    logic [YI-1:0]   r_j, n_j;
    logic [YI-1:0]   r_y0, n_y0;
    logic [CW-1:0]   r_code, n_code;
    logic [XC-1:0]   r_xl, n_xl, r_xr, n_xr;
    logic [YC-1:0]   r_yl, n_yl, r_yr, n_yr;
    logic [YC-1:0]   r_ys, n_ys, r_ye, n_ye;
    logic [XI-1:0]   r_xn, n_xn;
    logic            r_ret, n_ret;
    logic [CW-1:0]   r_best, n_best;
    logic [AW-1:0]   r_clr, n_clr;
    logic            r_ovalid, n_ovalid;
    logic            r_ofound, n_ofound;
    logic [9:0]      r_omax, n_omax;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [CW-1:0]   ram_wdata, ram_rdata;

    rrm_ram #(
        .WIDTH(CW),
        .DEPTH(2 ** AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
        r_i      <= n_i;
        r_j      <= n_j;
        r_y0     <= n_y0;
        r_code   <= n_code;
        r_xl     <= n_xl;
        r_xr     <= n_xr;
        r_yl     <= n_yl;
        r_yr     <= n_yr;
        r_ys     <= n_ys;
        r_ye     <= n_ye;
        r_xn     <= n_xn;
        r_ret    <= n_ret;
        r_best   <= n_best;
        r_ofound <= n_ofound;
        r_omax   <= n_omax;
    end

    always_comb begin
        int            xa, xb, ya, yb;
        logic [CW-1:0] best_m1;
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_y0      = r_y0;
        n_code    = r_code;
        n_xl      = r_xl;
        n_xr      = r_xr;
        n_yl      = r_yl;
        n_yr      = r_yr;
        n_ys      = r_ys;
        n_ye      = r_ye;
        n_xn      = r_xn;
        n_ret     = r_ret;
        n_best    = r_best;
        n_clr     = r_clr;
        n_ovalid  = 1'b0;
        n_ofound  = r_ofound;
        n_omax    = r_omax;
        ram_we    = 1'b0;
        ram_waddr = {r_i, r_j};
        ram_wdata = '0;
        ram_raddr = {r_xn, r_yl[YI-1:0]};
        best_m1   = r_best - CW'(1);

        // Query bounds in order, upper bounds cut to the grid.
        xa = int'(i_x_low);
        xb = int'(i_x_high);
        ya = int'(i_y_low);
        yb = int'(i_y_high);
        if (xa > xb) begin
            xa = int'(i_x_high);
            xb = int'(i_x_low);
        end
        if (ya > yb) begin
            ya = int'(i_y_high);
            yb = int'(i_y_low);
        end
        if (xb >= X_SIZE) begin
            xb = X_SIZE - 1;
        end
        if (yb >= Y_SIZE) begin
            yb = Y_SIZE - 1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_operation)
                        OP_INSERT: begin
                            n_code = {1'b0, VALUE_BITS'(i_value)} + CW'(1);
                            n_i    = XI'(int'(i_x_low) + X_SIZE);
                            n_j    = YI'(int'(i_y_low) + Y_SIZE);
                            n_y0   = YI'(int'(i_y_low) + Y_SIZE);
                            if (int'(i_x_low) < X_SIZE && int'(i_y_low) < Y_SIZE) begin
                                n_state = ST_INS_RD;
                            end
                        end
                        OP_QUERY: begin
                            n_best = '0;
                            n_xl   = XC'(xa + X_SIZE);
                            n_xr   = XC'(xb + X_SIZE + 1);
                            n_ys   = YC'(ya + Y_SIZE);
                            n_ye   = YC'(yb + Y_SIZE + 1);
                            if (xa >= X_SIZE || ya >= Y_SIZE) begin
                                n_ovalid = 1'b1;
                                n_ofound = 1'b0;
                                n_omax   = '0;
                            end else begin
                                n_state = ST_QX_L;
                            end
                        end
                        OP_CLEAR: begin
                            n_clr   = '0;
                            n_state = ST_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_INS_RD: begin
                ram_raddr = {r_i, r_j};
                n_state   = ST_INS_WR;
            end
            ST_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = {r_i, r_j};
                ram_wdata = (ram_rdata > r_code) ? ram_rdata : r_code;
                n_state   = ST_INS_RD;
                if (r_j == YI'(1)) begin
                    n_j = r_y0;
                    n_i = r_i >> 1;
                    if (r_i == XI'(1)) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_j = r_j >> 1;
                end
            end
            ST_QX_L: begin
                if (r_xl < r_xr) begin
                    if (r_xl[0]) begin
                        n_xn    = r_xl[XI-1:0];
                        n_xl    = r_xl + XC'(1);
                        n_yl    = r_ys;
                        n_yr    = r_ye;
                        n_ret   = 1'b0;
                        n_state = ST_QY_L;
                    end else begin
                        n_state = ST_QX_R;
                    end
                end else begin
                    n_ovalid = 1'b1;
                    n_ofound = (r_best != '0);
                    n_omax   = (r_best != '0) ? 10'(best_m1) : '0;
                    n_state  = ST_IDLE;
                end
            end
            ST_QX_R: begin
                if (r_xr[0]) begin
                    n_xr    = r_xr - XC'(1);
                    n_xn    = XI'(r_xr - XC'(1));
                    n_yl    = r_ys;
                    n_yr    = r_ye;
                    n_ret   = 1'b1;
                    n_state = ST_QY_L;
                end else begin
                    n_state = ST_QX_SH;
                end
            end
            ST_QX_SH: begin
                n_xl    = r_xl >> 1;
                n_xr    = r_xr >> 1;
                n_state = ST_QX_L;
            end
            ST_QY_L: begin
                ram_raddr = {r_xn, r_yl[YI-1:0]};
                if (r_yl < r_yr) begin
                    if (r_yl[0]) begin
                        n_yl    = r_yl + YC'(1);
                        n_state = ST_QY_LW;
                    end else begin
                        n_state = ST_QY_R;
                    end
                end else begin
                    n_state = r_ret ? ST_QX_SH : ST_QX_R;
                end
            end
            ST_QY_LW: begin
                n_best  = (ram_rdata > r_best) ? ram_rdata : r_best;
                n_state = ST_QY_R;
            end
            ST_QY_R: begin
                ram_raddr = {r_xn, YI'(r_yr - YC'(1))};
                if (r_yr[0]) begin
                    n_yr    = r_yr - YC'(1);
                    n_state = ST_QY_RW;
                end else begin
                    n_state = ST_QY_SH;
                end
            end
            ST_QY_RW: begin
                n_best  = (ram_rdata > r_best) ? ram_rdata : r_best;
                n_state = ST_QY_SH;
            end
            ST_QY_SH: begin
                n_yl    = r_yl >> 1;
                n_yr    = r_yr >> 1;
                n_state = ST_QY_L;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_valid     = r_ovalid;
    assign o_found     = r_ofound;
    assign o_max_value = r_omax;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import rrm_pkg::*;

    localparam int XS = X_SIZE_DEF;
    localparam int YS = Y_SIZE_DEF;
    // The clear pass after reset and a clear command each write all 2^19 RAM
    // words, so the watchdog limit must leave room for a whole pass.
    localparam int QUIET_LIMIT = 3000000;

    typedef struct {
        logic       found;
        logic [9:0] max_value;
    } t_answer;

    // Mirrors the store as a tree along x of trees along y. A node holds zero
    // when empty, otherwise the stored value plus one.
    class rect_max_scoreboard;
        logic [10:0] grid_node [0:2*XS-1][0:2*YS-1];
        t_answer     pending_answers[$];
        int          mismatches = 0;

        function void wipe();
            foreach (grid_node[i, j]) grid_node[i][j] = '0;
        endfunction

        function logic [10:0] column_max(int xn, int lo, int hi);
            logic [10:0] best;
            int l, r;
            best = '0;
            l = lo + YS;
            r = hi + YS + 1;
            while (l < r) begin
                if (l & 1) begin
                    if (grid_node[xn][l] > best) best = grid_node[xn][l];
                    l++;
                end
                if (r & 1) begin
                    r--;
                    if (grid_node[xn][r] > best) best = grid_node[xn][r];
                end
                l = l >> 1;
                r = r >> 1;
            end
            return best;
        endfunction

        function void note(logic [1:0] op, logic [6:0] xa, logic [6:0] xb,
                           logic [9:0] ya, logic [9:0] yb, logic [9:0] v);
            logic [10:0] best, c;
            t_answer     ans;
            int xl, xh, yl, yh, l, r;
            if (op == OP_CLEAR) begin
                wipe();
            end else if (op == OP_INSERT) begin
                for (int i = xa + XS; i >= 1; i = i >> 1)
                    for (int j = ya + YS; j >= 1; j = j >> 1)
                        if (grid_node[i][j] < v + 11'd1) grid_node[i][j] = v + 11'd1;
            end else if (op == OP_QUERY) begin
                // Reversed bound pairs are swapped before the walk.
                xl = (xa < xb) ? xa : xb;
                xh = (xa < xb) ? xb : xa;
                yl = (ya < yb) ? ya : yb;
                yh = (ya < yb) ? yb : ya;
                best = '0;
                l = xl + XS;
                r = xh + XS + 1;
                while (l < r) begin
                    if (l & 1) begin
                        c = column_max(l, yl, yh);
                        if (c > best) best = c;
                        l++;
                    end
                    if (r & 1) begin
                        r--;
                        c = column_max(r, yl, yh);
                        if (c > best) best = c;
                    end
                    l = l >> 1;
                    r = r >> 1;
                end
                ans.found     = (best != 0);
                ans.max_value = (best != 0) ? 10'(best - 11'd1) : 10'd0;
                pending_answers.push_back(ans);
            end
        endfunction

        function void check(logic found, logic [9:0] max_value);
            t_answer exp_ans;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result found=%0d max=%0d", $time,
                         found, max_value);
                mismatches++;
                return;
            end
            exp_ans = pending_answers.pop_front();
            if (found !== exp_ans.found) begin
                $display("%0t: found expected %0d actual %0d", $time,
                         exp_ans.found, found);
                mismatches++;
            end
            if (max_value !== exp_ans.max_value) begin
                $display("%0t: max_value expected %0d actual %0d", $time,
                         exp_ans.max_value, max_value);
                mismatches++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    logic [1:0] i_operation = OP_INSERT;
    logic [6:0] i_x_low = '0;
    logic [6:0] i_x_high = '0;
    logic [9:0] i_y_low = '0;
    logic [9:0] i_y_high = '0;
    logic [9:0] i_value = '0;
    logic       o_busy;
    logic       o_valid;
    logic       o_found;
    logic [9:0] o_max_value;

    rect_max_scoreboard store_model;
    int idle_pct = 0;
    int quiet_cycles = 0;

    rect_range_max_store_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_operation (i_operation),
        .i_x_low     (i_x_low),
        .i_x_high    (i_x_high),
        .i_y_low     (i_y_low),
        .i_y_high    (i_y_high),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_found     (o_found),
        .o_max_value (o_max_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Results cannot be held off, so every strobe is checked on the edge
    // that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) store_model.check(o_found, o_max_value);
    end

    // The watchdog restarts whenever a command beat or a result moves.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL rect_range_max_store_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drives one command beat and waits for the edge that takes it. The start
    // line is left high unless the task then idles it low for a random gap.
    task automatic send_command(logic [1:0] op, logic [6:0] xa, logic [6:0] xb,
                                logic [9:0] ya, logic [9:0] yb, logic [9:0] v);
        i_start     <= 1'b1;
        i_operation <= op;
        i_x_low     <= xa;
        i_x_high    <= xb;
        i_y_low     <= ya;
        i_y_high    <= yb;
        i_value     <= v;
        do @(posedge i_clk); while (o_busy);
        store_model.note(op, xa, xb, ya, yb, v);
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
    endtask

    // Most traffic lands in a small corner so that queries find stored values;
    // the rest spans the whole grid so every coordinate bit toggles.
    task automatic send_random();
        logic [6:0] xa, xb;
        logic [9:0] ya, yb;
        int pick;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 60) begin
            xa = 7'($urandom_range(15));
            xb = 7'($urandom_range(15));
            ya = 10'($urandom_range(31));
            yb = 10'($urandom_range(31));
        end else begin
            xa = 7'($urandom);
            xb = 7'($urandom);
            ya = 10'($urandom);
            yb = 10'($urandom);
        end
        if (pick < 47) send_command(OP_INSERT, xa, xb, ya, yb, 10'($urandom));
        else if (pick < 97) send_command(OP_QUERY, xa, xb, ya, yb, 10'($urandom));
        else send_command(OP_RESERVED, xa, xb, ya, yb, 10'($urandom));
    endtask

    initial begin
        store_model = new();
        store_model.wipe();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats: an empty store, both grid corners with extreme
        // values, a smaller value that must not lower a point, reversed
        // bounds, a single point, the unused code, and a clear.
        send_command(OP_QUERY, 7'd0, 7'd127, 10'd0, 10'd1023, 10'd0);
        send_command(OP_INSERT, 7'd0, 7'd0, 10'd0, 10'd0, 10'd0);
        send_command(OP_QUERY, 7'd0, 7'd0, 10'd0, 10'd0, 10'd0);
        send_command(OP_INSERT, 7'd127, 7'd0, 10'd1023, 10'd0, 10'd1023);
        send_command(OP_QUERY, 7'd127, 7'd0, 10'd1023, 10'd0, 10'd0);
        send_command(OP_INSERT, 7'd127, 7'd0, 10'd1023, 10'd0, 10'd5);
        send_command(OP_QUERY, 7'd127, 7'd127, 10'd1023, 10'd1023, 10'd0);
        send_command(OP_INSERT, 7'd64, 7'd0, 10'd512, 10'd0, 10'd300);
        send_command(OP_QUERY, 7'd100, 7'd10, 10'd600, 10'd400, 10'd0);
        send_command(OP_QUERY, 7'd63, 7'd0, 10'd1023, 10'd0, 10'd0);
        send_command(OP_QUERY, 7'd65, 7'd126, 10'd0, 10'd1022, 10'd0);
        send_command(OP_RESERVED, 7'd127, 7'd127, 10'd1023, 10'd1023, 10'd1023);
        send_command(OP_QUERY, 7'd0, 7'd127, 10'd0, 10'd1023, 10'd0);
        send_command(OP_CLEAR, 7'd0, 7'd0, 10'd0, 10'd0, 10'd0);
        send_command(OP_QUERY, 7'd127, 7'd0, 10'd1023, 10'd0, 10'd0);

        // Random phases: back to back, a mostly idle sender, then a light one.
        idle_pct = 0;
        repeat (270) send_random();
        idle_pct = 55;
        repeat (265) send_random();
        idle_pct = 6;
        repeat (265) send_random();

        i_start <= 1'b0;
        while (store_model.pending_answers.size() != 0) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (store_model.mismatches == 0 && store_model.pending_answers.size() == 0) begin
            $display("PASS rect_range_max_store_top");
        end else begin
            $display("FAIL rect_range_max_store_top");
        end
        $finish;
    end

endmodule
